FILE: sv/mmul4_pkg.sv
package mmul4_pkg;

   // Matrix geometry and number format
   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int CELLS     = DIM * DIM;
   localparam int POS_W     = 4;
   localparam int ELEM_W    = 32;
   localparam int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int DW        = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = PROD_W + DW;

   // Saturation bounds, sign-extended to the accumulator width
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-ELEM_W){1'b0}}, 1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-ELEM_W){1'b1}}, 1'b1, {(ELEM_W-1){1'b0}}};

   // Store write port
   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         addr;
      logic [ELEM_W-1:0]        a_elem;
      logic [ELEM_W-1:0]        b_elem;
   } wr_type;

   // Store read addresses
   typedef struct packed {
      logic [IDX_W-1:0]         addr_a;
      logic [IDX_W-1:0]         addr_b;
   } rd_type;

   // Control that travels with each product term
   typedef struct packed {
      logic                     vld;
      logic                     first;
      logic                     fin;
      logic [POS_W-1:0]         idx;
      logic                     last;
   } tag_type;

endpackage

FILE: sv/mmul4_store.sv
module mmul4_store
   import mmul4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  wr_type                   wr,
   input  rd_type                   rd,
   output logic signed [ELEM_W-1:0] a_data,
   output logic signed [ELEM_W-1:0] b_data
);

   logic [ELEM_W-1:0] left_mem  [CELLS];
   logic [ELEM_W-1:0] right_mem [CELLS];
   logic [CELLS-1:0]  valid_ff;
   logic [CELLS-1:0]  valid_in;
   logic [ELEM_W-1:0] a_rd_ff;
   logic [ELEM_W-1:0] b_rd_ff;
   logic              a_vld_ff;
   logic              b_vld_ff;

   // Entry valid bits: an unwritten entry reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         a_vld_ff <= valid_ff[rd.addr_a];
         b_vld_ff <= valid_ff[rd.addr_b];
      end
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (wr.en) begin
         left_mem[wr.addr]  <= wr.a_elem;
         right_mem[wr.addr] <= wr.b_elem;
      end
      a_rd_ff <= left_mem[rd.addr_a];
      b_rd_ff <= right_mem[rd.addr_b];
   end

   assign a_data = a_vld_ff ? a_rd_ff : '0;
   assign b_data = b_vld_ff ? b_rd_ff : '0;

endmodule

FILE: sv/mmul4_mac.sv
module mmul4_mac
   import mmul4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [ELEM_W-1:0] a_data,
   input  logic signed [ELEM_W-1:0] b_data,
   input  tag_type                  tag,
   output logic                     rsp_strobe,
   output logic [POS_W-1:0]         rsp_position,
   output logic signed [ELEM_W-1:0] rsp_elem,
   output logic                     rsp_last
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   tag_type                  tag1_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   tag_type                  tag2_ff;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [ELEM_W-1:0] sat_in;
   logic                     strobe_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [ELEM_W-1:0] elem_ff;
   logic                     last_ff;

   // Multiply stage
   assign prod_in = a_data * b_data;

   // Accumulate stage, restarted on the first term of each element
   assign acc_in = (tag1_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);

   // Scale and saturate
   assign shifted = acc_ff >>> FRAC_BITS;
   always_comb begin
      if (shifted > SAT_HI) begin
         sat_in = SAT_HI[ELEM_W-1:0];
      end else if (shifted < SAT_LO) begin
         sat_in = SAT_LO[ELEM_W-1:0];
      end else begin
         sat_in = shifted[ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff   <= '0;
         tag2_ff   <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         tag1_ff   <= tag;
         tag2_ff   <= tag1_ff;
         strobe_ff <= tag2_ff.vld && tag2_ff.fin;
         last_ff   <= tag2_ff.vld && tag2_ff.fin && tag2_ff.last;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag1_ff.vld) begin
         acc_ff <= acc_in;
      end
      pos_ff  <= tag2_ff.idx;
      elem_ff <= sat_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_position = pos_ff;
   assign rsp_elem     = elem_ff;
   assign rsp_last     = last_ff;

endmodule

FILE: sv/matrix4x4_multiply_core.sv
// Square matrix product in signed Q16.16. Each accepted beat writes one element of the left
// and one of the right matrix at a row-major position; a beat at the last position also
// starts the product. A product runs one multiply-accumulate per cycle, set by the single
// read port of each element memory, through the read, multiply, accumulate and output
// registers; each result sums DIM products. busy is registered: it rises after the
// starting beat and stays high through the cycle of the final result; start is ignored
// while busy. The receiver cannot stall: each result is on the rsp_ ports for one cycle
// under rsp_strobe. Positions beyond the matrix are ignored. Both matrices read as zero
// after reset and keep their contents between products.
module matrix4x4_multiply_core
   import mmul4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [ELEM_W-1:0] req_a_elem,
   input  logic signed [ELEM_W-1:0] req_b_elem,
   output logic                     rsp_strobe,
   output logic [POS_W-1:0]         rsp_out_position,
   output logic signed [ELEM_W-1:0] rsp_out_elem,
   output logic                     rsp_out_last
);

   localparam logic [IDX_W-1:0]       DIM_IDX  = IDX_W'(DIM);
   localparam logic [DW-1:0]          DIM_TOP  = DW'(DIM - 1);
   localparam logic [IDX_W+POS_W-1:0] CELLS_X  = (IDX_W + POS_W)'(CELLS);
   localparam logic [IDX_W+POS_W-1:0] LAST_X   = (IDX_W + POS_W)'(CELLS - 1);

   logic                     busy_ff, busy_in;
   logic                     run_ff, run_in;
   logic [DW-1:0]            r_ff, r_in;
   logic [DW-1:0]            c_ff, c_in;
   logic [DW-1:0]            k_ff, k_in;
   tag_type                  tag_rd_ff;
   tag_type                  tag_issue;
   wr_type                   wr;
   rd_type                   rd;
   logic                     accept;
   logic [IDX_W+POS_W-1:0]   pos_ext;
   logic                     go;
   logic [IDX_W-1:0]         out_idx;
   logic [IDX_W+POS_W-1:0]   out_idx_ext;
   logic signed [ELEM_W-1:0] a_data;
   logic signed [ELEM_W-1:0] b_data;
   logic                     k_end, c_end, r_end;

   // Load beat: written only while idle, so no read of the product can overlap it
   assign accept  = start && !busy_ff;
   assign pos_ext = {{IDX_W{1'b0}}, req_position};
   assign go      = accept && (pos_ext == LAST_X);

   assign wr.en     = accept && (pos_ext < CELLS_X);
   assign wr.addr   = pos_ext[IDX_W-1:0];
   assign wr.a_elem = req_a_elem;
   assign wr.b_elem = req_b_elem;

   // Sequencer over row, column and inner index
   assign k_end = (k_ff == DIM_TOP);
   assign c_end = (c_ff == DIM_TOP);
   assign r_end = (r_ff == DIM_TOP);

   always_comb begin
      run_in = run_ff;
      r_in   = r_ff;
      c_in   = c_ff;
      k_in   = k_ff;
      if (go) begin
         run_in = 1'b1;
         r_in   = '0;
         c_in   = '0;
         k_in   = '0;
      end else if (run_ff) begin
         k_in = k_end ? '0 : k_ff + 1'b1;
         if (k_end) begin
            c_in = c_end ? '0 : c_ff + 1'b1;
            if (c_end) begin
               r_in = r_ff + 1'b1;
               if (r_end) begin
                  run_in = 1'b0;
                  r_in   = '0;
               end
            end
         end
      end
   end

   // Busy until the final result has gone out
   always_comb begin
      busy_in = busy_ff;
      if (go) begin
         busy_in = 1'b1;
      end else if (rsp_strobe && rsp_out_last) begin
         busy_in = 1'b0;
      end
   end

   // Read addresses: left row r, right column c, inner index k
   assign rd.addr_a = IDX_W'(r_ff) * DIM_IDX + IDX_W'(k_ff);
   assign rd.addr_b = IDX_W'(k_ff) * DIM_IDX + IDX_W'(c_ff);

   assign out_idx     = IDX_W'(r_ff) * DIM_IDX + IDX_W'(c_ff);
   assign out_idx_ext = {{POS_W{1'b0}}, out_idx};

   assign tag_issue.vld   = run_ff;
   assign tag_issue.first = (k_ff == '0);
   assign tag_issue.fin   = k_end;
   assign tag_issue.idx   = out_idx_ext[POS_W-1:0];
   assign tag_issue.last  = k_end && c_end && r_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         run_ff    <= 1'b0;
         r_ff      <= '0;
         c_ff      <= '0;
         k_ff      <= '0;
         tag_rd_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         run_ff    <= run_in;
         r_ff      <= r_in;
         c_ff      <= c_in;
         k_ff      <= k_in;
         tag_rd_ff <= tag_issue;
      end
   end

   assign busy = busy_ff;

   mmul4_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd     (rd),
      .a_data (a_data),
      .b_data (b_data)
   );

   mmul4_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .a_data       (a_data),
      .b_data       (b_data),
      .tag          (tag_rd_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_position (rsp_out_position),
      .rsp_elem     (rsp_out_elem),
      .rsp_last     (rsp_out_last)
   );

endmodule

FILE: sv/mmul4_checker.sv
module mmul4_checker
   import mmul4_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [POS_W-1:0]  req_position,
   input logic              rsp_strobe,
   input logic              rsp_out_last
);

   // Results only appear during a product
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while not busy");

   // The final beat ends the product
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !busy)
      else $error("busy did not drop after final beat");

   // Busy rises only from an accepted start beat
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

   // A beat at the last position starts a product
   a_go: assert property (@(posedge clock) disable iff (reset)
      (CELLS <= 16) && start && !busy && (req_position == POS_W'(CELLS - 1)) |=> busy)
      else $error("last position did not start a product");

   // No results for a product while idle the cycle before
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("result beat right after idle");

endmodule

bind matrix4x4_multiply_core mmul4_checker u_mmul4_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_position (req_position),
   .rsp_strobe   (rsp_strobe),
   .rsp_out_last (rsp_out_last)
);
